// ===== rtl/tekd_pkg.sv =====
// Shared types and constants for the terminal escape key decoder.
`timescale 1ns / 1ps
`default_nettype none

package tekd_pkg;

    // Byte codes recognized by the parser
    localparam logic [7:0] C_ESC       = 8'h1B;
    localparam logic [7:0] C_LBRACKET  = 8'h5B;
    localparam logic [7:0] C_SEMICOLON = 8'h3B;
    localparam logic [7:0] C_TILDE     = 8'h7E;
    localparam logic [7:0] C_CTRL_TOP  = 8'h20;
    localparam logic [7:0] C_LF        = 8'h0A;
    localparam logic [7:0] C_DIGIT_1   = 8'h31;
    localparam logic [7:0] C_DIGIT_2   = 8'h32;
    localparam logic [7:0] C_DIGIT_3   = 8'h33;
    localparam logic [7:0] C_DIGIT_5   = 8'h35;
    localparam logic [7:0] C_DIGIT_6   = 8'h36;
    localparam logic [7:0] C_UPPER_A   = 8'h41;
    localparam logic [7:0] C_UPPER_B   = 8'h42;
    localparam logic [7:0] C_UPPER_C   = 8'h43;
    localparam logic [7:0] C_UPPER_D   = 8'h44;
    localparam logic [7:0] C_UPPER_F   = 8'h46;
    localparam logic [7:0] C_UPPER_H   = 8'h48;
    localparam logic [7:0] C_LOWER_A   = 8'h61;
    localparam logic [7:0] C_LOWER_Z   = 8'h7A;

    // Key codes produced
    localparam logic [7:0] K_ESC   = 8'h1B;
    localparam logic [7:0] K_LEFT  = 8'd28;
    localparam logic [7:0] K_RIGHT = 8'd29;
    localparam logic [7:0] K_UP    = 8'd30;
    localparam logic [7:0] K_DOWN  = 8'd31;
    localparam logic [7:0] K_INS   = 8'd5;
    localparam logic [7:0] K_DEL   = 8'd5;
    localparam logic [7:0] K_PRIOR = 8'd11;
    localparam logic [7:0] K_NEXT  = 8'd12;
    localparam logic [7:0] K_HOME  = 8'd1;
    localparam logic [7:0] K_END   = 8'd127;

    // Modifier mask bits
    localparam logic [3:0] M_NONE    = 4'h0;
    localparam logic [3:0] M_SHIFT   = 4'h1;
    localparam logic [3:0] M_CONTROL = 4'h2;
    localparam logic [3:0] M_COMMAND = 4'h8;

    // Parser states
    typedef enum logic [3:0] {
        S_IDLE = 4'd0,
        S_ESC  = 4'd1,
        S_CSI  = 4'd2,
        S_C1   = 4'd3,
        S_C1S  = 4'd4,
        S_C1S2 = 4'd5,
        S_C2   = 4'd6,
        S_C3   = 4'd7,
        S_C5   = 4'd8,
        S_C6   = 4'd9
    } t_parse_state;

    // One decoded key event
    typedef struct packed {
        logic       valid;
        logic [7:0] key_code;
        logic [3:0] modifiers;
    } t_key_event;

    // Control modifier for keys in the control range
    function automatic logic [3:0] plain_mods(input logic [7:0] key);
        plain_mods = (key < C_CTRL_TOP) ? M_CONTROL : M_NONE;
    endfunction

    // Arrow key for a final letter, zero when not an arrow
    function automatic logic [7:0] arrow_of(input logic [7:0] c);
        case (c)
            C_UPPER_A: arrow_of = K_UP;
            C_UPPER_B: arrow_of = K_DOWN;
            C_UPPER_C: arrow_of = K_RIGHT;
            C_UPPER_D: arrow_of = K_LEFT;
            default:   arrow_of = 8'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tekd_parser.sv =====
// Escape sequence parser: state register and per-byte decode logic.
`timescale 1ns / 1ps
`default_nettype none

module tekd_parser
    import tekd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_step,
    input  wire  [7:0] i_byte,
    output t_key_event o_event
);

    t_parse_state r_state;
    t_parse_state n_state;
    logic [7:0]   w_arrow;

    // State register, advanced once per processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    assign w_arrow = arrow_of(i_byte);

    // Next state and key event for the current byte
    always_comb begin
        n_state             = S_IDLE;
        o_event.valid       = 1'b0;
        o_event.key_code    = i_byte;
        o_event.modifiers   = M_NONE;
        case (r_state)
            S_ESC: begin
                if (i_byte == C_LBRACKET) begin
                    n_state = S_CSI;
                end else if (i_byte inside {[C_LOWER_A:C_LOWER_Z]}) begin
                    o_event.valid     = 1'b1;
                    o_event.modifiers = M_COMMAND;
                end else begin
                    // lone escape, this byte is dropped
                    o_event.valid     = 1'b1;
                    o_event.key_code  = K_ESC;
                    o_event.modifiers = plain_mods(K_ESC);
                end
            end
            S_CSI: begin
                case (i_byte)
                    C_DIGIT_1: n_state = S_C1;
                    C_DIGIT_2: n_state = S_C2;
                    C_DIGIT_3: n_state = S_C3;
                    C_DIGIT_5: n_state = S_C5;
                    C_DIGIT_6: n_state = S_C6;
                    C_UPPER_F: begin
                        o_event.valid     = 1'b1;
                        o_event.key_code  = K_END;
                        o_event.modifiers = plain_mods(K_END);
                    end
                    C_UPPER_H: begin
                        o_event.valid     = 1'b1;
                        o_event.key_code  = K_HOME;
                        o_event.modifiers = plain_mods(K_HOME);
                    end
                    default: begin
                        if (w_arrow != 8'd0) begin
                            o_event.valid     = 1'b1;
                            o_event.key_code  = w_arrow;
                            o_event.modifiers = plain_mods(w_arrow);
                        end
                    end
                endcase
            end
            S_C1: begin
                if (i_byte == C_SEMICOLON) begin
                    n_state = S_C1S;
                end
            end
            S_C1S: begin
                if (i_byte == C_DIGIT_2) begin
                    n_state = S_C1S2;
                end
            end
            S_C1S2: begin
                // shifted arrow
                if (w_arrow != 8'd0) begin
                    o_event.valid     = 1'b1;
                    o_event.key_code  = w_arrow;
                    o_event.modifiers = M_SHIFT;
                end
            end
            S_C2, S_C3, S_C5, S_C6: begin
                // key picked from the state held before the tilde
                if (i_byte == C_TILDE) begin
                    o_event.valid = 1'b1;
                    case (r_state)
                        S_C2:    o_event.key_code = K_INS;
                        S_C3:    o_event.key_code = K_DEL;
                        S_C5:    o_event.key_code = K_PRIOR;
                        default: o_event.key_code = K_NEXT;
                    endcase
                    o_event.modifiers = plain_mods(o_event.key_code);
                end
            end
            default: begin
                // idle, and any unused code behaves as idle
                if (i_byte == C_ESC) begin
                    n_state = S_ESC;
                end else if (i_byte != C_LF) begin
                    o_event.valid     = 1'b1;
                    o_event.modifiers = plain_mods(i_byte);
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/terminal_escape_key_decoder.sv =====
// Top level: input register, escape parser and registered key output.
//
// Usage:
//   Slave stream (i_s_axis_*) takes one received terminal byte per transfer.
//   Master stream (o_m_axis_*) delivers decoded key events: key code and a
//   modifier mask (bit0 shift, bit1 control, bit3 command).
//   A byte that completes a key gives one output transfer; bytes that only
//   advance an escape sequence, and line feeds, give none.
// Path: a byte taken into the input register is decoded by the parser, and its
//   key event is captured in the output register once the output slot is
//   free; the master side presents the event from that register.
// Throughput: one byte per cycle while the receiver takes each output, limited
//   by the single parse-state register that each byte updates.
// Reset: synchronous, active low; both stages empty, parser back to idle.
// Stall: while the receiver holds tready low the output register keeps its
//   event, one more byte waits in the input register, and then tready on
//   the slave side drops until the output is taken.
`timescale 1ns / 1ps
`default_nettype none

module terminal_escape_key_decoder
    import tekd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [7:0] key_code, [11:8] modifiers, [15:12] zero
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [7:0] r_out_key;
    logic [3:0] r_out_mods;

    logic       w_out_free;
    logic       w_step;
    t_key_event w_event;

    // Handshake: decode the held byte whenever the output slot can take it
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_step          = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    tekd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .o_event (w_event)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step && w_event.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_event.valid) begin
            r_out_key  <= w_event.key_code;
            r_out_mods <= w_event.modifiers;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_mods, r_out_key};

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking stream testbench for the terminal escape key decoder.
`timescale 1ns / 1ps

module testbench;
    import tekd_pkg::*;

    // Expected key event on the master side
    typedef struct {
        logic [7:0] key;
        logic [3:0] mods;
    } t_decoded_key;

    // Byte waiting to be sent; hold_for_drain stalls the sender until all keys are out
    typedef struct {
        logic [7:0] data;
        bit         hold_for_drain;
    } t_rx_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    t_rx_item     rx_bytes_to_send[$];
    t_decoded_key expected_keys[$];
    t_parse_state parser_state = S_IDLE;
    int           total_items;
    int           sent_count;
    int           mismatch_count;
    bit           byte_taken;

    terminal_escape_key_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),    // [7:0] rx_byte
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)     // [7:0] key_code, [11:8] modifiers, [15:12] zero
    );

    always #6 i_clk = ~i_clk;

    // Control bit for keys in the control range
    function automatic logic [3:0] ctrl_mask(input logic [7:0] key);
        return (key < C_CTRL_TOP) ? M_CONTROL : M_NONE;
    endfunction

    // Final letter of an arrow sequence; zero when it is not one
    function automatic logic [7:0] final_to_arrow(input logic [7:0] c);
        case (c)
            C_UPPER_A: return K_UP;
            C_UPPER_B: return K_DOWN;
            C_UPPER_C: return K_RIGHT;
            C_UPPER_D: return K_LEFT;
            default:   return 8'd0;
        endcase
    endfunction

    // Advance the parser by one byte; returns 1 when a key event results
    function automatic bit decode_rx_byte(input logic [7:0] c, output t_decoded_key ev);
        t_parse_state was;
        logic [7:0]   arrow;
        bit           hit;
        was = parser_state;
        arrow = final_to_arrow(c);
        parser_state = S_IDLE;
        hit = 1'b0;
        ev.key = 8'd0;
        ev.mods = M_NONE;
        case (was)
            S_ESC: begin
                if (c == C_LBRACKET) begin
                    parser_state = S_CSI;
                end else if (c >= C_LOWER_A && c <= C_LOWER_Z) begin
                    hit = 1'b1; ev.key = c; ev.mods = M_COMMAND;
                end else begin
                    // lone escape, the byte itself is dropped
                    hit = 1'b1; ev.key = K_ESC; ev.mods = ctrl_mask(K_ESC);
                end
            end
            S_CSI: begin
                case (c)
                    C_DIGIT_1: parser_state = S_C1;
                    C_DIGIT_2: parser_state = S_C2;
                    C_DIGIT_3: parser_state = S_C3;
                    C_DIGIT_5: parser_state = S_C5;
                    C_DIGIT_6: parser_state = S_C6;
                    C_UPPER_F: begin hit = 1'b1; ev.key = K_END; end
                    C_UPPER_H: begin hit = 1'b1; ev.key = K_HOME; end
                    default: begin
                        if (arrow != 8'd0) begin hit = 1'b1; ev.key = arrow; end
                    end
                endcase
                ev.mods = ctrl_mask(ev.key);
            end
            S_C1: begin
                if (c == C_SEMICOLON) parser_state = S_C1S;
            end
            S_C1S: begin
                if (c == C_DIGIT_2) parser_state = S_C1S2;
            end
            S_C1S2: begin
                if (arrow != 8'd0) begin
                    hit = 1'b1; ev.key = arrow; ev.mods = M_SHIFT;
                end
            end
            S_C2, S_C3, S_C5, S_C6: begin
                // key depends on the digit seen before the tilde
                if (c == C_TILDE) begin
                    hit = 1'b1;
                    case (was)
                        S_C2:    ev.key = K_INS;
                        S_C3:    ev.key = K_DEL;
                        S_C5:    ev.key = K_PRIOR;
                        default: ev.key = K_NEXT;
                    endcase
                    ev.mods = ctrl_mask(ev.key);
                end
            end
            default: begin
                if (c == C_ESC) begin
                    parser_state = S_ESC;
                end else if (c != C_LF) begin
                    hit = 1'b1; ev.key = c; ev.mods = ctrl_mask(c);
                end
            end
        endcase
        return hit;
    endfunction

    task automatic push_byte(input logic [7:0] data, input bit hold = 1'b0);
        t_rx_item item;
        item.data = data;
        item.hold_for_drain = hold;
        rx_bytes_to_send.push_back(item);
    endtask

    task automatic push_csi();
        push_byte(C_ESC);
        push_byte(C_LBRACKET);
    endtask

    // One random sequence, mostly well formed, with noise and broken prefixes
    task automatic push_random_sequence();
        logic [7:0] specials[6];
        logic [7:0] digits[4];
        specials = '{C_UPPER_A, C_UPPER_B, C_UPPER_C, C_UPPER_D, C_UPPER_F, C_UPPER_H};
        digits = '{C_DIGIT_2, C_DIGIT_3, C_DIGIT_5, C_DIGIT_6};
        case ($urandom_range(0, 9))
            0, 1: push_byte(8'($urandom_range(0, 255)));
            2: begin
                push_byte(C_ESC);
                push_byte(8'($urandom_range(C_LOWER_A, C_LOWER_Z)));
            end
            3: begin
                push_csi();
                push_byte(specials[$urandom_range(0, 5)]);
            end
            4: begin
                push_csi();
                push_byte(C_DIGIT_1);
                push_byte(C_SEMICOLON);
                push_byte(C_DIGIT_2);
                push_byte(8'($urandom_range(C_UPPER_A, C_UPPER_D)));
            end
            5: begin
                push_csi();
                push_byte(digits[$urandom_range(0, 3)]);
                push_byte(C_TILDE);
            end
            6: begin
                push_csi();
                if ($urandom_range(0, 1)) push_byte(digits[$urandom_range(0, 3)]);
                push_byte(8'($urandom_range(0, 255)));
            end
            7: begin
                // shifted arrow cut short, then a random byte
                push_csi();
                push_byte(C_DIGIT_1);
                if ($urandom_range(0, 1)) begin
                    push_byte(C_SEMICOLON);
                    if ($urandom_range(0, 1)) push_byte(C_DIGIT_2);
                end
                push_byte(8'($urandom_range(0, 255)));
            end
            8: push_byte(C_LF);
            default: begin
                push_byte(C_ESC);
                push_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Driver: slave-side valid/data and master-side ready, changed on the falling edge
    always @(negedge i_clk) begin
        int send_pct;
        int recv_pct;
        if (sent_count < total_items / 3) begin
            send_pct = 19; recv_pct = 47;
        end else if (sent_count < (2 * total_items) / 3) begin
            send_pct = 47; recv_pct = 19;
        end else begin
            send_pct = 0;  recv_pct = 0;
        end
        if (i_rst_n) begin
            m_tready <= ($urandom_range(0, 99) >= recv_pct);
            if (!s_tvalid || byte_taken) begin
                if (rx_bytes_to_send.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (rx_bytes_to_send[0].hold_for_drain && expected_keys.size() != 0) begin
                    s_tvalid <= 1'b0;
                end else if ($urandom_range(0, 99) < send_pct) begin
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_bytes_to_send[0].data;
                    void'(rx_bytes_to_send.pop_front());
                    sent_count++;
                end
            end
        end
        byte_taken = 1'b0;
    end

    // Monitor: predict on each byte transfer, check each key transfer
    always @(posedge i_clk) begin
        t_decoded_key ev;
        t_decoded_key want;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                byte_taken = 1'b1;
                if (decode_rx_byte(s_tdata, ev)) expected_keys.push_back(ev);
            end
            if (m_tvalid && m_tready) begin
                if (expected_keys.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ERROR unexpected key transfer: expected none, got %04h",
                             $realtime, m_tdata);
                end else begin
                    want = expected_keys.pop_front();
                    if (m_tdata[7:0] !== want.key || m_tdata[11:8] !== want.mods ||
                        m_tdata[15:12] !== 4'h0) begin
                        mismatch_count++;
                        $display("%0t ERROR key mismatch: expected key %02h mods %h, got %04h",
                                 $realtime, want.key, want.mods, m_tdata);
                    end
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        // plain byte extremes and line feed
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(C_LF);
        push_byte(8'h1F);
        push_byte(C_CTRL_TOP);
        // command letters and a lone escape on an uppercase letter
        push_byte(C_ESC); push_byte(C_LOWER_A);
        push_byte(C_ESC); push_byte(C_LOWER_Z);
        push_byte(C_ESC); push_byte(C_UPPER_A);
        // arrow, end, shifted arrow, insert
        push_csi(); push_byte(C_UPPER_B);
        push_csi(); push_byte(C_UPPER_F);
        push_csi(); push_byte(C_DIGIT_1); push_byte(C_SEMICOLON);
        push_byte(C_DIGIT_2); push_byte(C_UPPER_D);
        push_csi(); push_byte(C_DIGIT_2); push_byte(C_TILDE);
        // digit sequence broken before the tilde
        push_csi(); push_byte(C_DIGIT_6); push_byte(8'h30);

        // random part; the sender waits for a full drain now and then
        while (rx_bytes_to_send.size() < 450) begin
            if (rx_bytes_to_send.size() % 100 < 5 && $urandom_range(0, 3) == 0) begin
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            push_random_sequence();
        end
        rx_bytes_to_send[30].hold_for_drain = 1'b1;
        total_items = rx_bytes_to_send.size();

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_bytes_to_send.size() != 0 || s_tvalid) @(posedge i_clk);
        while (expected_keys.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);

        if (mismatch_count == 0 && expected_keys.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("%0t ERROR timeout with %0d keys outstanding", $realtime, expected_keys.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tekd_pkg.sv
rtl/tekd_parser.sv
rtl/terminal_escape_key_decoder.sv
test/testbench.sv
